// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while out of reset.
`define BLIT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define BLIT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/blit_pkg.sv -----
// Types and constants of the clipped rectangle fill and copy blitter.
package blit_pkg;

  localparam int unsigned MAX_DIM_DEF = 8192;
  localparam int unsigned COORD_W     = 14;
  localparam int unsigned STRIDE_W    = 17;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned PIX_SHIFT   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FB_BASE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FB_WIDTH   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_FB_HEIGHT  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE = CFG_IDX_W'(3);

  localparam logic [COORD_W-1:0]  FB_WIDTH_RST  = COORD_W'(1024);
  localparam logic [COORD_W-1:0]  FB_HEIGHT_RST = COORD_W'(768);
  localparam logic [STRIDE_W-1:0] STRIDE_RST    = STRIDE_W'(4096);

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    OP_STEP,
    OP_CLEAR,
    OP_FILL,
    OP_COPY
  } op_e;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_MOVE,
    KIND_REFUSED
  } kind_e;

endpackage

// ----- rtl/core/blit_if.sv -----
// Request, result and configuration channel interfaces of the blitter.
interface blit_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] dst_x;
  logic [15:0] dst_y;
  logic [15:0] src_x;
  logic [15:0] src_y;
  logic [15:0] rect_width;
  logic [15:0] rect_height;
  logic [31:0] fill_colour;

  modport source (output valid, op, dst_x, dst_y, src_x, src_y, rect_width, rect_height,
                  fill_colour, input ready);
  modport sink (input valid, op, dst_x, dst_y, src_x, src_y, rect_width, rect_height,
                fill_colour, output ready);
endinterface

interface blit_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] write_addr;
  logic [31:0] read_addr;
  logic [31:0] pixel_value;
  logic        last;

  modport source (output valid, kind, write_addr, read_addr, pixel_value, last, input ready);
  modport sink (input valid, kind, write_addr, read_addr, pixel_value, last, output ready);
endinterface

interface blit_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [blit_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/blit_pix_addr.sv -----
// Byte address of one framebuffer pixel from its column and row.
module blit_pix_addr (
  input  logic [blit_pkg::ADDR_W-1:0]   base_i,
  input  logic [blit_pkg::STRIDE_W-1:0] stride_i,
  input  blit_pkg::coord_t              col_i,
  input  blit_pkg::coord_t              row_i,
  output logic [blit_pkg::ADDR_W-1:0]   addr_o
);

  logic [blit_pkg::COORD_W+blit_pkg::STRIDE_W-1:0] row_off;
  logic [blit_pkg::COORD_W+blit_pkg::PIX_SHIFT-1:0] col_off;

  assign row_off = row_i * stride_i;
  assign col_off = {col_i, {blit_pkg::PIX_SHIFT{1'b0}}};
  assign addr_o  = base_i + blit_pkg::ADDR_W'(row_off) + blit_pkg::ADDR_W'(col_off);

endmodule

// ----- rtl/core/clipped_rect_fill_copy_blitter.sv -----
// Clipped rectangle fill and copy blitter: top level.
// A result is registered and presented in the cycle after the request that causes it is accepted.
// One request per cycle while the result output is not stalled; commands and steps alike are taken at that rate.
// The output register frees while the result is taken, so requests flow without gaps.
// Reset: idle, no result pending, registers at 0, 1024, 768 and 4096.
module clipped_rect_fill_copy_blitter #(
  parameter int unsigned MAX_DIM = blit_pkg::MAX_DIM_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  blit_cfg_if.sink   cfg_i,
  blit_req_if.sink   req_i,
  blit_res_if.source res_o
);

  localparam int unsigned CW   = blit_pkg::COORD_W;
  localparam int unsigned DimW = CW + 1;
  localparam logic [DimW-1:0] MaxDim = DimW'(MAX_DIM);

  logic [blit_pkg::ADDR_W-1:0]   fb_base_q;
  blit_pkg::coord_t              fb_width_q, fb_height_q;
  logic [blit_pkg::STRIDE_W-1:0] stride_q;

  logic             busy_q, busy_d;
  logic             copy_q, copy_d;
  logic             rev_q, rev_d;
  blit_pkg::coord_t cur_col_q, cur_col_d;
  blit_pkg::coord_t cur_row_q, cur_row_d;
  blit_pkg::coord_t first_col_q, first_col_d;
  blit_pkg::coord_t end_col_q, end_col_d;
  blit_pkg::coord_t end_row_q, end_row_d;
  blit_pkg::coord_t src_col_off_q, src_col_off_d;
  blit_pkg::coord_t src_row_off_q, src_row_off_d;
  logic [31:0]      colour_q, colour_d;

  logic                  res_valid_q, res_valid_d;
  blit_pkg::kind_e       res_kind_q, res_kind_d;
  logic [31:0]           res_waddr_q, res_waddr_d;
  logic [31:0]           res_raddr_q, res_raddr_d;
  logic [31:0]           res_pix_q, res_pix_d;
  logic                  res_last_q, res_last_d;

  logic             req_ready, req_acc, is_step, is_copy, is_clear, is_last;
  blit_pkg::coord_t eff_w, eff_h;
  blit_pkg::coord_t fx0, fy0, fx1, fy1, ax0, ay0, ax1, ay1;
  logic [16:0]      fx1_sum, fy1_sum;
  logic             fill_empty;
  blit_pkg::coord_t lim_sx, lim_dx, lim_sy, lim_dy, cw_a, ch_a, cw, ch;
  blit_pkg::coord_t c_last_col, c_last_row;
  logic             copy_empty;
  logic [32:0]      dst_prod, src_prod;
  logic [33:0]      dst_off, src_off;
  logic             copy_rev;
  blit_pkg::coord_t src_col, src_row;
  logic [31:0]      dst_addr, src_addr;

  // Configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_base_q   <= '0;
      fb_width_q  <= blit_pkg::FB_WIDTH_RST;
      fb_height_q <= blit_pkg::FB_HEIGHT_RST;
      stride_q    <= blit_pkg::STRIDE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        blit_pkg::CFG_FB_BASE:    fb_base_q   <= cfg_i.data;
        blit_pkg::CFG_FB_WIDTH:   fb_width_q  <= cfg_i.data[CW-1:0];
        blit_pkg::CFG_FB_HEIGHT:  fb_height_q <= cfg_i.data[CW-1:0];
        blit_pkg::CFG_ROW_STRIDE: stride_q    <= cfg_i.data[blit_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign req_ready   = !res_valid_q || res_o.ready;
  assign req_i.ready = req_ready;
  assign req_acc     = req_i.valid && req_ready;
  assign is_step     = req_i.op == blit_pkg::OP_STEP;
  assign is_copy     = req_i.op == blit_pkg::OP_COPY;
  assign is_clear    = req_i.op == blit_pkg::OP_CLEAR;

  // Clip window
  assign eff_w = ({1'b0, fb_width_q} > MaxDim) ? MaxDim[CW-1:0] : fb_width_q;
  assign eff_h = ({1'b0, fb_height_q} > MaxDim) ? MaxDim[CW-1:0] : fb_height_q;

  // Fill and clear region
  assign fx0     = (req_i.dst_x > 16'(eff_w)) ? eff_w : req_i.dst_x[CW-1:0];
  assign fy0     = (req_i.dst_y > 16'(eff_h)) ? eff_h : req_i.dst_y[CW-1:0];
  assign fx1_sum = 17'(fx0) + 17'(req_i.rect_width);
  assign fy1_sum = 17'(fy0) + 17'(req_i.rect_height);
  assign fx1     = (fx1_sum > 17'(eff_w)) ? eff_w : fx1_sum[CW-1:0];
  assign fy1     = (fy1_sum > 17'(eff_h)) ? eff_h : fy1_sum[CW-1:0];
  assign ax0     = is_clear ? '0 : fx0;
  assign ay0     = is_clear ? '0 : fy0;
  assign ax1     = is_clear ? eff_w : fx1;
  assign ay1     = is_clear ? eff_h : fy1;
  assign fill_empty = (ax0 == ax1) || (ay0 == ay1);

  // Copy region
  assign lim_sx = eff_w - req_i.src_x[CW-1:0];
  assign lim_dx = eff_w - req_i.dst_x[CW-1:0];
  assign lim_sy = eff_h - req_i.src_y[CW-1:0];
  assign lim_dy = eff_h - req_i.dst_y[CW-1:0];
  assign cw_a   = (req_i.rect_width < 16'(lim_sx)) ? req_i.rect_width[CW-1:0] : lim_sx;
  assign ch_a   = (req_i.rect_height < 16'(lim_sy)) ? req_i.rect_height[CW-1:0] : lim_sy;
  assign cw     = (cw_a < lim_dx) ? cw_a : lim_dx;
  assign ch     = (ch_a < lim_dy) ? ch_a : lim_dy;
  assign c_last_col = req_i.dst_x[CW-1:0] + cw - CW'(1);
  assign c_last_row = req_i.dst_y[CW-1:0] + ch - CW'(1);
  assign copy_empty = (req_i.src_x >= 16'(eff_w)) || (req_i.dst_x >= 16'(eff_w)) ||
                      (req_i.src_y >= 16'(eff_h)) || (req_i.dst_y >= 16'(eff_h)) ||
                      (req_i.rect_width == '0) || (req_i.rect_height == '0);

  // Column direction for overlapping copies
  assign dst_prod = req_i.dst_y * stride_q;
  assign src_prod = req_i.src_y * stride_q;
  assign dst_off  = 34'(dst_prod) + 34'({req_i.dst_x, 2'b00});
  assign src_off  = 34'(src_prod) + 34'({req_i.src_x, 2'b00});
  assign copy_rev = dst_off > src_off;

  // Pixel addresses
  assign src_col = cur_col_q + src_col_off_q;
  assign src_row = cur_row_q + src_row_off_q;

  blit_pix_addr u_dst_addr (
    .base_i  (fb_base_q),
    .stride_i(stride_q),
    .col_i   (cur_col_q),
    .row_i   (cur_row_q),
    .addr_o  (dst_addr)
  );

  blit_pix_addr u_src_addr (
    .base_i  (fb_base_q),
    .stride_i(stride_q),
    .col_i   (src_col),
    .row_i   (src_row),
    .addr_o  (src_addr)
  );

  assign is_last = (cur_col_q == end_col_q) && (cur_row_q == end_row_q);

  always_comb begin
    busy_d        = busy_q;
    copy_d        = copy_q;
    rev_d         = rev_q;
    cur_col_d     = cur_col_q;
    cur_row_d     = cur_row_q;
    first_col_d   = first_col_q;
    end_col_d     = end_col_q;
    end_row_d     = end_row_q;
    src_col_off_d = src_col_off_q;
    src_row_off_d = src_row_off_q;
    colour_d      = colour_q;

    res_valid_d = res_valid_q && !res_o.ready;
    res_kind_d  = res_kind_q;
    res_waddr_d = res_waddr_q;
    res_raddr_d = res_raddr_q;
    res_pix_d   = res_pix_q;
    res_last_d  = res_last_q;

    if (req_acc) begin
      res_valid_d = busy_q;
      if (!is_step) begin
        if (busy_q) begin
          res_kind_d  = blit_pkg::KIND_REFUSED;
          res_waddr_d = '0;
          res_raddr_d = '0;
          res_pix_d   = '0;
          res_last_d  = 1'b0;
        end else if (is_copy) begin
          copy_d        = 1'b1;
          colour_d      = '0;
          src_col_off_d = req_i.src_x[CW-1:0] - req_i.dst_x[CW-1:0];
          src_row_off_d = req_i.src_y[CW-1:0] - req_i.dst_y[CW-1:0];
          if (!copy_empty) begin
            rev_d       = copy_rev;
            first_col_d = copy_rev ? c_last_col : req_i.dst_x[CW-1:0];
            end_col_d   = copy_rev ? req_i.dst_x[CW-1:0] : c_last_col;
            cur_col_d   = copy_rev ? c_last_col : req_i.dst_x[CW-1:0];
            cur_row_d   = req_i.dst_y[CW-1:0];
            end_row_d   = c_last_row;
            busy_d      = 1'b1;
          end
        end else begin
          copy_d        = 1'b0;
          colour_d      = req_i.fill_colour;
          src_col_off_d = '0;
          src_row_off_d = '0;
          if (!fill_empty) begin
            rev_d       = 1'b0;
            first_col_d = ax0;
            end_col_d   = ax1 - CW'(1);
            cur_col_d   = ax0;
            cur_row_d   = ay0;
            end_row_d   = ay1 - CW'(1);
            busy_d      = 1'b1;
          end
        end
      end else if (busy_q) begin
        res_kind_d  = copy_q ? blit_pkg::KIND_MOVE : blit_pkg::KIND_WRITE;
        res_waddr_d = dst_addr;
        res_raddr_d = copy_q ? src_addr : '0;
        res_pix_d   = copy_q ? '0 : colour_q;
        res_last_d  = is_last;
        if (is_last) begin
          busy_d = 1'b0;
        end else if (cur_col_q == end_col_q) begin
          cur_col_d = first_col_q;
          cur_row_d = cur_row_q + CW'(1);
        end else if (rev_q) begin
          cur_col_d = cur_col_q - CW'(1);
        end else begin
          cur_col_d = cur_col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      copy_q        <= 1'b0;
      rev_q         <= 1'b0;
      cur_col_q     <= '0;
      cur_row_q     <= '0;
      first_col_q   <= '0;
      end_col_q     <= '0;
      end_row_q     <= '0;
      src_col_off_q <= '0;
      src_row_off_q <= '0;
      colour_q      <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      busy_q        <= busy_d;
      copy_q        <= copy_d;
      rev_q         <= rev_d;
      cur_col_q     <= cur_col_d;
      cur_row_q     <= cur_row_d;
      first_col_q   <= first_col_d;
      end_col_q     <= end_col_d;
      end_row_q     <= end_row_d;
      src_col_off_q <= src_col_off_d;
      src_row_off_q <= src_row_off_d;
      colour_q      <= colour_d;
      res_valid_q   <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_kind_q  <= res_kind_d;
    res_waddr_q <= res_waddr_d;
    res_raddr_q <= res_raddr_d;
    res_pix_q   <= res_pix_d;
    res_last_q  <= res_last_d;
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.kind        = res_kind_q;
  assign res_o.write_addr  = res_waddr_q;
  assign res_o.read_addr   = res_raddr_q;
  assign res_o.pixel_value = res_pix_q;
  assign res_o.last        = res_last_q;

endmodule

// ----- rtl/core/blit_checker.sv -----
// Port checker of the blitter and its binding to the top level.
`include "assert_macros.svh"

module blit_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  res_kind,
  input logic [31:0] res_write_addr,
  input logic [31:0] res_read_addr,
  input logic [31:0] res_pixel_value,
  input logic        res_last
);

  `BLIT_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !res_valid, "result during reset")

  `BLIT_ASSERT(a_res_hold, clk_i, rst_ni, res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_write_addr) && $stable(res_last), "stalled result changed")

  `BLIT_ASSERT(a_ready_when_empty, clk_i, rst_ni, !res_valid |-> req_ready, "request refused with empty output")

  `BLIT_ASSERT(a_refused_zero, clk_i, rst_ni, res_valid && res_kind == blit_pkg::KIND_REFUSED |-> res_write_addr == '0 && res_read_addr == '0 && res_pixel_value == '0 && !res_last, "refused result carries data")

  `BLIT_ASSERT(a_op_fields, clk_i, rst_ni, res_valid && res_kind != blit_pkg::KIND_REFUSED |-> (res_kind == blit_pkg::KIND_MOVE ? res_pixel_value == '0 : res_read_addr == '0), "unused field not zero")

endmodule

bind clipped_rect_fill_copy_blitter blit_port_checker u_blit_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_ready      (req_i.ready),
  .res_valid      (res_o.valid),
  .res_ready      (res_o.ready),
  .res_kind       (res_o.kind),
  .res_write_addr (res_o.write_addr),
  .res_read_addr  (res_o.read_addr),
  .res_pixel_value(res_o.pixel_value),
  .res_last       (res_o.last)
);
